// ===== hdl/fba_pkg.sv =====
// ---------------------------------------------------------------------------
// fba_pkg
// Shared types, codes and helpers of the frame bitmap allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package fba_pkg;

  localparam int          WORD_BITS       = 32;
  localparam int          BIT_W           = 5;
  localparam int          FRAME_W         = 15;
  localparam int          GWORD_W         = FRAME_W - BIT_W;
  localparam int          WORDS_W         = 11;
  localparam logic [31:0] ALL_USED        = 32'hFFFF_FFFF;
  localparam logic [WORDS_W-1:0] MAX_GRANT_WORDS = 11'd1024;

  typedef enum logic [1:0] {
    ACT_ALLOC     = 2'd0,
    ACT_FREE      = 2'd1,
    ACT_MARK_USED = 2'd2,
    ACT_MARK_FREE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY,
    ST_SEARCH
  } state_t;

  // Position of the lowest clear bit; the word must not be all ones.
  // Halve the window five times, refilling the vacated top with ones.
  function automatic logic [BIT_W-1:0] low_zero(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] v;
    logic [BIT_W-1:0]     pos;
    v   = w;
    pos = '0;
    if (&v[15:0]) begin
      pos[4] = 1'b1;
      v      = {16'hFFFF, v[31:16]};
    end
    if (&v[7:0]) begin
      pos[3] = 1'b1;
      v      = {8'hFF, v[31:8]};
    end
    if (&v[3:0]) begin
      pos[2] = 1'b1;
      v      = {4'hF, v[31:4]};
    end
    if (&v[1:0]) begin
      pos[1] = 1'b1;
      v      = {2'b11, v[31:2]};
    end
    if (v[0]) begin
      pos[0] = 1'b1;
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/fba_ram.sv =====
// ---------------------------------------------------------------------------
// fba_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fba_engine.sv =====
// ---------------------------------------------------------------------------
// fba_engine
// Sequencer of the allocator: clearing pass, read-modify-write of one bitmap
// word for free and mark, and a pipelined word-by-word first-fit search.
// ---------------------------------------------------------------------------
`default_nettype none

module fba_engine #(
  parameter int BITMAP_WORDS = 1024,
  localparam int AW          = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [1:0]                    action,
  input  wire logic [fba_pkg::FRAME_W-1:0]   frame_index,
  input  wire logic [fba_pkg::WORDS_W-1:0]   frame_words,
  output logic                               busy,
  output logic                               done,
  output logic      [fba_pkg::FRAME_W-1:0]   granted_frame,
  output logic                               out_of_memory,
  output logic                               mem_we,
  output logic      [AW-1:0]                 mem_waddr,
  output logic      [fba_pkg::WORD_BITS-1:0] mem_wdata,
  output logic                               mem_re,
  output logic      [AW-1:0]                 mem_raddr,
  input  wire logic [fba_pkg::WORD_BITS-1:0] mem_rdata
);
  import fba_pkg::*;

  localparam logic [WORDS_W-1:0] DEPTH_CAP =
    (BITMAP_WORDS < 1024) ? WORDS_W'(BITMAP_WORDS) : MAX_GRANT_WORDS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(BITMAP_WORDS - 1);

  state_t             state, state_next;
  logic [AW-1:0]      clr_cnt, clr_cnt_next;
  logic [GWORD_W-1:0] chk_cnt, chk_cnt_next;
  action_t            act;
  logic [GWORD_W-1:0] widx;
  logic [BIT_W-1:0]   bpos;
  logic               in_range;

  logic               done_next;
  logic [FRAME_W-1:0] granted_next;
  logic               oom_next;

  logic [WORDS_W-1:0] lim;
  logic               accept;
  logic               found;
  logic               last_word;
  logic [BIT_W-1:0]   hit_bit;
  logic [WORDS_W-1:0] chk_plus;
  logic [WORD_BITS-1:0] bit_mask;

  // Search bound: smaller of the register and the searchable depth
  assign lim = (frame_words < DEPTH_CAP) ? frame_words : DEPTH_CAP;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign found     = (mem_rdata != ALL_USED);
  assign hit_bit   = low_zero(mem_rdata);
  assign chk_plus  = WORDS_W'(chk_cnt) + WORDS_W'(1);
  assign last_word = (chk_plus == lim);
  assign bit_mask  = WORD_BITS'(1) << bpos;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == LAST_ADDR) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (action != ACT_ALLOC)  state_next = ST_MODIFY;
          else if (lim != '0)       state_next = ST_SEARCH;
        end
      end
      ST_MODIFY: begin
        state_next = ST_IDLE;
      end
      ST_SEARCH: begin
        if (found || last_word) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory controls and result
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = AW'(chk_cnt);
    mem_wdata    = mem_rdata;
    mem_re       = 1'b0;
    mem_raddr    = AW'(chk_plus);
    clr_cnt_next = clr_cnt;
    chk_cnt_next = chk_cnt;
    done_next    = 1'b0;
    granted_next = '0;
    oom_next     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_cnt;
        mem_wdata    = ALL_USED;
        clr_cnt_next = clr_cnt + AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          if (action != ACT_ALLOC) begin
            // read the word that holds the frame
            mem_re    = 1'b1;
            mem_raddr = AW'(frame_index[FRAME_W-1:BIT_W]);
          end else if (lim != '0) begin
            mem_re       = 1'b1;
            mem_raddr    = '0;
            chk_cnt_next = '0;
          end else begin
            done_next = 1'b1;
            oom_next  = 1'b1;
          end
        end
      end
      ST_MODIFY: begin
        mem_we    = in_range;
        mem_waddr = AW'(widx);
        mem_wdata = (act == ACT_MARK_USED) ? (mem_rdata | bit_mask)
                                           : (mem_rdata & ~bit_mask);
        done_next = 1'b1;
      end
      ST_SEARCH: begin
        if (found) begin
          done_next = 1'b1;
          if ((chk_cnt == '0) && (hit_bit == '0)) begin
            // lowest free frame is frame zero: treat as failure
            oom_next = 1'b1;
          end else begin
            mem_we       = 1'b1;
            mem_waddr    = AW'(chk_cnt);
            mem_wdata    = mem_rdata | (WORD_BITS'(1) << hit_bit);
            granted_next = {chk_cnt, hit_bit};
          end
        end else if (last_word) begin
          done_next = 1'b1;
          oom_next  = 1'b1;
        end else begin
          // advance to the next word, one read per cycle
          mem_re       = 1'b1;
          mem_raddr    = AW'(chk_plus);
          chk_cnt_next = chk_plus[GWORD_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      done    <= done_next;
    end
  end

  // Transaction and result registers
  always_ff @(posedge clk) begin
    chk_cnt       <= chk_cnt_next;
    granted_frame <= granted_next;
    out_of_memory <= oom_next;
    if (accept) begin
      act      <= action_t'(action);
      widx     <= frame_index[FRAME_W-1:BIT_W];
      bpos     <= frame_index[BIT_W-1:0];
      in_range <= (32'(frame_index[FRAME_W-1:BIT_W]) < BITMAP_WORDS);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/frame_bitmap_allocator.sv =====
// ---------------------------------------------------------------------------
// frame_bitmap_allocator
// First-fit page frame allocator over a bitmap held in one word-wide RAM.
// ---------------------------------------------------------------------------
// After reset the block runs a clearing pass over all BITMAP_WORDS words
// that marks every frame used; busy is high throughout. A transaction is
// taken when start is high and busy is low. Free and mark read the word,
// then write it back; the result strobe done follows in the cycle after
// the write-back. An alloc reads one bitmap word per cycle through the RAM
// read port and stops at the first word that is not full, reading from one
// word up to the search limit, with done in the cycle after the last word;
// with a search limit of zero the result comes in the cycle after start is
// taken. Results are shown for exactly one cycle and cannot be held off;
// a new start may be taken in the cycle that done is high.
// ---------------------------------------------------------------------------
`default_nettype none

module frame_bitmap_allocator #(
  parameter int BITMAP_WORDS = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  action,
  input  wire logic [fba_pkg::FRAME_W-1:0] frame_index,
  output logic                             done,
  output logic      [fba_pkg::FRAME_W-1:0] granted_frame,
  output logic                             out_of_memory,
  input  wire logic                        cfg_we,
  input  wire logic [fba_pkg::WORDS_W-1:0] cfg_data
);
  import fba_pkg::*;

  localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

  logic [WORDS_W-1:0]   frame_words;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;

  // Hold the search-length register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_words <= MAX_GRANT_WORDS;
    end else if (cfg_we) begin
      frame_words <= cfg_data;
    end
  end

  fba_engine #(
    .BITMAP_WORDS (BITMAP_WORDS)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .action        (action),
    .frame_index   (frame_index),
    .frame_words   (frame_words),
    .busy          (busy),
    .done          (done),
    .granted_frame (granted_frame),
    .out_of_memory (out_of_memory),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  fba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BITMAP_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== hdl/fba_checker.sv =====
// ---------------------------------------------------------------------------
// fba_checker
// Port-level checks of the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module fba_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done,
  input wire logic [fba_pkg::FRAME_W-1:0] granted_frame,
  input wire logic                        out_of_memory
);

  // No result right after reset
  a_no_done_after_reset: assert property (
    @(posedge clk) $past(rst) |-> !done
  ) else $error("done raised right after reset");

  // A result only follows a taken transaction or a busy cycle
  a_done_has_cause: assert property (
    @(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy))
  ) else $error("done without a transaction in flight");

  // A taken transaction either starts work or answers at once
  a_accept_progress: assert property (
    @(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done)
  ) else $error("transaction taken but neither busy nor done");

  // A failed alloc grants frame zero
  a_oom_zero_grant: assert property (
    @(posedge clk) disable iff (rst)
    (done && out_of_memory) |-> (granted_frame == '0)
  ) else $error("out_of_memory with a nonzero granted_frame");

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (.*);

`default_nettype wire

// ===== verif/frame_bitmap_allocator_tb.sv =====
// ---------------------------------------------------------------------------
// frame_bitmap_allocator_tb
// Self-checking bench for the first-fit page frame allocator. A queue of
// pending requests, filled up front, feeds a clocked driver. The driver
// predicts each accepted transaction against its own copy of the bitmap and
// search limit. A clocked monitor compares every done strobe with the oldest
// prediction. Directed corner cases come first, then random phases under
// varied search limits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_bitmap_allocator_tb;
  import fba_pkg::*;

  localparam int MAP_WORDS   = 1024;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int TAIL_CYCLES = 40;

  typedef enum logic [1:0] {
    REQ_OP,
    REQ_WORDS,
    REQ_DRAIN
  } req_kind_t;

  typedef struct {
    req_kind_t            kind;
    action_t              act;
    logic [FRAME_W-1:0]   frame;
    logic [WORDS_W-1:0]   words;
    int                   gap;
  } frame_req_t;

  typedef struct {
    logic [FRAME_W-1:0] granted;
    logic               oom;
  } grant_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [1:0]           action = 2'd0;
  logic [FRAME_W-1:0]   frame_index = '0;
  logic                 cfg_we = 1'b0;
  logic [WORDS_W-1:0]   cfg_data = '0;
  logic                 busy;
  logic                 done;
  logic [FRAME_W-1:0]   granted_frame;
  logic                 out_of_memory;

  frame_req_t           request_q[$];
  grant_t               grant_q[$];
  logic [31:0]          frame_map [MAP_WORDS];
  logic [WORDS_W-1:0]   model_words;
  int                   fail_cnt = 0;
  int                   cycle_cnt = 0;

  frame_bitmap_allocator #(
    .BITMAP_WORDS(MAP_WORDS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .frame_index  (frame_index),
    .done         (done),
    .granted_frame(granted_frame),
    .out_of_memory(out_of_memory),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one transaction to the bitmap copy and return its expected result
  function automatic grant_t predict_grant(action_t act, logic [FRAME_W-1:0] frame);
    grant_t             r;
    int                 lim;
    logic               found;
    logic [FRAME_W-1:0] hit;
    r.granted = '0;
    r.oom     = 1'b0;
    case (act)
      ACT_ALLOC: begin
        lim   = (model_words > MAP_WORDS) ? MAP_WORDS : int'(model_words);
        found = 1'b0;
        hit   = '0;
        for (int w = 0; w < lim && !found; w++) begin
          if (frame_map[w] != ALL_USED) begin
            for (int b = 0; b < WORD_BITS && !found; b++) begin
              if (!frame_map[w][b]) begin
                found = 1'b1;
                hit   = FRAME_W'(w * WORD_BITS + b);
              end
            end
          end
        end
        // A free frame 0 counts as a failed search
        if (found && hit != '0) begin
          frame_map[hit[FRAME_W-1:BIT_W]][hit[BIT_W-1:0]] = 1'b1;
          r.granted = hit;
        end else begin
          r.oom = 1'b1;
        end
      end
      ACT_MARK_USED: frame_map[frame[FRAME_W-1:BIT_W]][frame[BIT_W-1:0]] = 1'b1;
      default:       frame_map[frame[FRAME_W-1:BIT_W]][frame[BIT_W-1:0]] = 1'b0;
    endcase
    return r;
  endfunction

  task automatic push_op(action_t act, int frame, int gap);
    frame_req_t q;
    q.kind  = REQ_OP;
    q.act   = act;
    q.frame = FRAME_W'(frame);
    q.words = '0;
    q.gap   = gap;
    request_q.push_back(q);
  endtask

  task automatic push_ctrl(req_kind_t kind, int words);
    frame_req_t q;
    q.kind  = kind;
    q.act   = ACT_ALLOC;
    q.frame = '0;
    q.words = WORDS_W'(words);
    q.gap   = 0;
    request_q.push_back(q);
  endtask

  // Driver: present pending transactions, write the limit only when idle
  frame_req_t head;
  grant_t     pred;
  logic       nxt_start;
  logic       nxt_we;
  logic       idle;
  int         gap_cnt = 0;

  always @(posedge clk) begin
    if (rst) begin
      start  <= 1'b0;
      cfg_we <= 1'b0;
      gap_cnt = 0;
      for (int w = 0; w < MAP_WORDS; w++) frame_map[w] = ALL_USED;
      model_words = MAX_GRANT_WORDS;
    end else begin
      if (cfg_we) model_words = cfg_data;
      nxt_start = start;
      nxt_we    = 1'b0;
      if (start && !busy) begin
        pred = predict_grant(action_t'(action), frame_index);
        grant_q.push_back(pred);
        nxt_start = 1'b0;
      end
      idle = !nxt_start && !busy && !cfg_we && grant_q.size() == 0;
      if (!nxt_start && request_q.size() > 0) begin
        head = request_q[0];
        case (head.kind)
          REQ_OP: begin
            if (gap_cnt < head.gap) begin
              gap_cnt++;
            end else begin
              void'(request_q.pop_front());
              gap_cnt = 0;
              action      <= head.act;
              frame_index <= head.frame;
              nxt_start   = 1'b1;
            end
          end
          REQ_WORDS: begin
            if (idle) begin
              void'(request_q.pop_front());
              cfg_data <= head.words;
              nxt_we   = 1'b1;
            end
          end
          default: begin
            if (idle) void'(request_q.pop_front());
          end
        endcase
      end
      start  <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  // Monitor: compare each done strobe with the oldest prediction
  grant_t seen;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (grant_q.size() == 0) begin
        $error("unexpected result: granted_frame %0d out_of_memory %0b",
               granted_frame, out_of_memory);
        fail_cnt++;
      end else begin
        seen = grant_q.pop_front();
        if (granted_frame !== seen.granted) begin
          $error("granted_frame: expected %0d, got %0d", seen.granted, granted_frame);
          fail_cnt++;
        end
        if (out_of_memory !== seen.oom) begin
          $error("out_of_memory: expected %0b, got %0b", seen.oom, out_of_memory);
          fail_cnt++;
        end
      end
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus, end of run
  initial begin
    int      fw;
    int      region;
    int      frame;
    int      pick;
    int      gap;
    bit      burst;
    action_t act;

    // Full map at reset: deepest failing search
    push_op(ACT_ALLOC, 0, 0);
    // Zero words searched
    push_ctrl(REQ_WORDS, 0);
    push_op(ACT_FREE, 7, 3);
    push_op(ACT_ALLOC, 0, 0);
    // Limit above the map size; grant the topmost frame
    push_ctrl(REQ_WORDS, 2047);
    push_op(ACT_FREE, 32767, 0);
    push_op(ACT_ALLOC, 0, 11);
    push_op(ACT_ALLOC, 0, 0);
    // One word: a free frame 0 blocks the search
    push_ctrl(REQ_WORDS, 1);
    push_op(ACT_MARK_USED, 7, 0);
    push_op(ACT_FREE, 0, 2);
    push_op(ACT_ALLOC, 0, 0);
    push_op(ACT_MARK_FREE, 5, 0);
    push_op(ACT_ALLOC, 0, 1);
    push_op(ACT_MARK_USED, 0, 0);
    push_op(ACT_ALLOC, 0, 0);
    push_op(ACT_FREE, 31, 5);
    push_op(ACT_ALLOC, 0, 0);
    push_op(ACT_ALLOC, 0, 0);
    // Second word reached past a full first word
    push_ctrl(REQ_WORDS, 2);
    push_op(ACT_MARK_FREE, 32, 0);
    push_op(ACT_ALLOC, 0, 0);
    // Alternating bit patterns at full limit
    push_ctrl(REQ_WORDS, 1024);
    push_op(ACT_MARK_FREE, 21845, 4);
    push_op(ACT_FREE, 10922, 0);
    push_op(ACT_ALLOC, 0, 0);
    push_op(ACT_ALLOC, 0, 9);
    push_op(ACT_ALLOC, 0, 0);
    push_ctrl(REQ_DRAIN, 0);

    // Random phases, each under its own search limit
    for (int p = 0; p < 12; p++) begin
      case (p % 6)
        0:       fw = $urandom_range(1, 4);
        1:       fw = 1;
        2:       fw = $urandom_range(5, 16);
        3:       fw = (p < 6) ? 1024 : 2047;
        4:       fw = $urandom_range(0, 2047);
        default: fw = 2;
      endcase
      push_ctrl(REQ_WORDS, fw);
      region = (fw == 0) ? 1 : ((fw > MAP_WORDS) ? MAP_WORDS : fw);
      burst  = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 85; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      act = ACT_ALLOC;
        else if (pick < 70) act = ACT_FREE;
        else if (pick < 85) act = ACT_MARK_USED;
        else                act = ACT_MARK_FREE;
        // Mostly within the searched words, now and then anywhere
        if ($urandom_range(0, 9) == 0) frame = $urandom_range(0, 32767);
        else                           frame = $urandom_range(0, region * WORD_BITS - 1);
        if (act == ACT_ALLOC && $urandom_range(0, 1) == 0) frame = $urandom_range(0, 32767);
        gap = burst ? 0 : $urandom_range(0, 11);
        push_op(act, frame, gap);
        // Hold off until every prediction has been retired
        if (i == 40) push_ctrl(REQ_DRAIN, 0);
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Drain stimulus and outstanding results
    @(negedge clk);
    while (request_q.size() != 0 || grant_q.size() != 0 || start || busy) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (grant_q.size() != 0) begin
      $error("%0d expected results never arrived", grant_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
